>>> design/mtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int OUT_WIDTH  = 32;

    typedef enum logic [2:0] {
        CMD_LOAD_CUR = 3'd0,
        CMD_LOAD_OP  = 3'd1,
        CMD_IDENT    = 3'd2,
        CMD_MUL      = 3'd3,
        CMD_ADD      = 3'd4,
        CMD_XFORM    = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MAC,
        OP_ADD,
        OP_LOAD,
        OP_IDENT,
        OP_COMMIT
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;
        logic [1:0] j;
        logic [1:0] row;
        logic       last;
    } t_ctl;

    typedef struct packed {
        logic res_valid;
        logic ovf;
        logic done;
    } t_stat;

endpackage

`default_nettype wire

>>> design/mtu_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mtu_cell #(
    parameter int       ELEM_WIDTH = mtu_pkg::ELEM_WIDTH,
    parameter int       FRAC_BITS  = mtu_pkg::FRAC_BITS,
    parameter int       BUS_WIDTH  = 32,
    parameter bit [1:0] IDX        = 2'd0
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire mtu_pkg::t_ctl               i_ctl,
    input  wire logic signed [BUS_WIDTH-1:0] i_bv [4],
    output mtu_pkg::t_ctl                    o_ctl,
    output logic signed [BUS_WIDTH-1:0]      o_bv [4],
    output mtu_pkg::t_stat                   o_stat,
    output logic signed [ELEM_WIDTH-1:0]     o_res
);

    localparam int PW = ELEM_WIDTH + BUS_WIDTH;
    localparam int AW = PW + 2;
    localparam logic [ELEM_WIDTH-1:0] ONE_VAL = (FRAC_BITS < ELEM_WIDTH - 1) ?
        (ELEM_WIDTH'(1) << FRAC_BITS) : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic signed [ELEM_WIDTH-1:0] r_row [4];
    logic signed [ELEM_WIDTH-1:0] r_tmp [4];
    mtu_pkg::t_ctl                r_ctl;
    logic signed [BUS_WIDTH-1:0]  r_bv [4];
    logic signed [PW-1:0]         r_s1;
    logic signed [PW-1:0]         n_s1;
    logic signed [AW-1:0]         r_acc;
    logic signed [AW-1:0]         n_acc;
    logic signed [AW-1:0]         w_sh;
    logic                         w_mac_ovf;
    logic signed [ELEM_WIDTH-1:0] w_mac_res;
    logic [ELEM_WIDTH:0]          w_sum;
    logic                         w_add_ovf;
    logic signed [ELEM_WIDTH-1:0] w_add_res;
    mtu_pkg::t_stat               r_stat;
    mtu_pkg::t_stat               n_stat;
    logic signed [ELEM_WIDTH-1:0] r_res;

    assign o_ctl  = r_ctl;
    assign o_bv   = r_bv;
    assign o_stat = r_stat;
    assign o_res  = r_res;

    // stage 1: multiply or add against this row, else pass the operand through
    always_comb begin
        case (i_ctl.op)
            mtu_pkg::OP_MAC: n_s1 = r_row[i_ctl.k] * i_bv[IDX];
            mtu_pkg::OP_ADD: n_s1 = PW'(r_row[i_ctl.k]) + PW'(i_bv[IDX]);
            default:         n_s1 = PW'(i_bv[IDX]);
        endcase
    end

    // stage 2: accumulate, shift, saturate
    always_comb begin
        n_acc     = ((r_ctl.k == 2'd0) ? AW'(0) : r_acc) + AW'(r_s1);
        w_sh      = n_acc >>> FRAC_BITS;
        w_mac_ovf = !((&w_sh[AW-1:ELEM_WIDTH-1]) || (~|w_sh[AW-1:ELEM_WIDTH-1]));
        w_mac_res = w_mac_ovf ? (w_sh[AW-1] ? MIN_VAL : MAX_VAL) : w_sh[ELEM_WIDTH-1:0];
        w_sum     = r_s1[ELEM_WIDTH:0];
        w_add_ovf = w_sum[ELEM_WIDTH] ^ w_sum[ELEM_WIDTH-1];
        w_add_res = w_add_ovf ? (w_sum[ELEM_WIDTH] ? MIN_VAL : MAX_VAL)
                              : w_sum[ELEM_WIDTH-1:0];
    end

    always_comb begin
        n_stat      = '0;
        n_stat.done = r_ctl.last;
        case (r_ctl.op)
            mtu_pkg::OP_MAC: begin
                if (r_ctl.k == 2'd3) begin
                    n_stat.res_valid = 1'b1;
                    n_stat.ovf       = w_mac_ovf;
                end
            end
            mtu_pkg::OP_ADD: n_stat.ovf = w_add_ovf;
            default:         n_stat.ovf = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_stat <= '0;
            for (int c = 0; c < 4; c++) begin
                r_row[c] <= (c == int'(IDX)) ? ONE_VAL : '0;
            end
        end else begin
            r_ctl  <= i_ctl;
            r_stat <= n_stat;
            case (r_ctl.op)
                mtu_pkg::OP_LOAD: begin
                    if (r_ctl.row == IDX) begin
                        r_row[r_ctl.k] <= r_s1[ELEM_WIDTH-1:0];
                    end
                end
                mtu_pkg::OP_IDENT: begin
                    for (int c = 0; c < 4; c++) begin
                        r_row[c] <= (c == int'(IDX)) ? ONE_VAL : '0;
                    end
                end
                mtu_pkg::OP_COMMIT: r_row <= r_tmp;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_bv <= i_bv;
        r_s1 <= n_s1;
        case (r_ctl.op)
            mtu_pkg::OP_MAC: begin
                r_acc <= n_acc;
                if (r_ctl.k == 2'd3) begin
                    r_tmp[r_ctl.j] <= w_mac_res;
                    r_res          <= w_mac_res;
                end
            end
            mtu_pkg::OP_ADD: r_tmp[r_ctl.k] <= w_add_res;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> design/matrix4x4_transform_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// 4x4 matrix engine, Q16.16 by default. One result beat per command beat.
// Four row cells form a chain: each holds one row of the current matrix and
// passes the operand stream to the next cell in the next cycle. Load operand
// and unused commands skip the chain and go straight to the result; multiply
// feeds 16 MAC steps per cell, then a commit. One command is in flight at
// a time.
module matrix4x4_transform_unit_core #(
    parameter int FRAC_BITS  = mtu_pkg::FRAC_BITS,
    parameter int ELEM_WIDTH = mtu_pkg::ELEM_WIDTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [2:0]         i_cmd,
    input  wire  [3:0]         i_elem_index,
    input  wire  signed [31:0] i_elem_value,
    input  wire  signed [31:0] i_vec_x,
    input  wire  signed [31:0] i_vec_y,
    input  wire  signed [31:0] i_vec_z,
    input  wire  signed [31:0] i_vec_w,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_overflow
);

    localparam int BW = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;
    localparam logic [ELEM_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    mtu_pkg::t_state              r_state;
    mtu_pkg::t_state              n_state;
    mtu_pkg::t_cmd                r_cmd;
    logic [3:0]                   r_idx;
    logic signed [ELEM_WIDTH-1:0] r_val;
    logic signed [31:0]           r_vec [4];
    logic signed [ELEM_WIDTH-1:0] r_opm [16];
    logic [4:0]                   r_cnt;
    logic [4:0]                   w_cnt_end;
    logic signed [31:0]           r_out [4];
    logic                         r_ovf;
    logic                         w_acc_in;
    logic                         w_acc_out;
    logic                         w_feed;
    logic                         w_no_work;

    logic signed [63:0]           w_lv_ext;
    logic signed [63:0]           w_lv_hi;
    logic signed [ELEM_WIDTH-1:0] w_lv_sat;

    mtu_pkg::t_ctl                w_ctl [5];
    logic signed [BW-1:0]         w_bv  [5][4];
    mtu_pkg::t_stat               w_stat [4];
    logic signed [ELEM_WIDTH-1:0] w_res  [4];
    logic signed [31:0]           w_res32 [4];
    logic [3:0]                   w_res_ovf;
    logic                         w_any_ovf;

    assign w_acc_in  = i_valid && !o_stall;
    assign w_acc_out = o_valid && !i_stall;
    assign o_stall   = (r_state != mtu_pkg::ST_IDLE);
    assign o_valid   = (r_state == mtu_pkg::ST_DONE);
    assign o_out_x   = r_out[0];
    assign o_out_y   = r_out[1];
    assign o_out_z   = r_out[2];
    assign o_out_w   = r_out[3];
    assign o_overflow = r_ovf;
    assign w_feed    = (r_state == mtu_pkg::ST_FEED);

    assign w_no_work = (mtu_pkg::t_cmd'(i_cmd) == mtu_pkg::CMD_LOAD_OP) ||
                       (mtu_pkg::t_cmd'(i_cmd) == mtu_pkg::CMD_RSVD6)   ||
                       (mtu_pkg::t_cmd'(i_cmd) == mtu_pkg::CMD_RSVD7);

    // load value clamp to element range
    always_comb begin
        w_lv_ext = 64'(i_elem_value);
        w_lv_hi  = w_lv_ext >>> (ELEM_WIDTH - 1);
        if (w_lv_hi == 64'sd0 || w_lv_hi == -64'sd1) begin
            w_lv_sat = w_lv_ext[ELEM_WIDTH-1:0];
        end else begin
            w_lv_sat = w_lv_ext[63] ? MIN_VAL : MAX_VAL;
        end
    end

    always_comb begin
        case (r_cmd)
            mtu_pkg::CMD_MUL:   w_cnt_end = 5'd16;
            mtu_pkg::CMD_ADD:   w_cnt_end = 5'd4;
            mtu_pkg::CMD_XFORM: w_cnt_end = 5'd3;
            default:            w_cnt_end = 5'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtu_pkg::ST_IDLE: begin
                if (w_acc_in) begin
                    n_state = w_no_work ? mtu_pkg::ST_DONE : mtu_pkg::ST_FEED;
                end
            end
            mtu_pkg::ST_FEED: begin
                if (r_cnt == w_cnt_end) n_state = mtu_pkg::ST_WAIT;
            end
            mtu_pkg::ST_WAIT: begin
                if (w_stat[3].done) n_state = mtu_pkg::ST_DONE;
            end
            mtu_pkg::ST_DONE: begin
                if (w_acc_out) n_state = mtu_pkg::ST_IDLE;
            end
            default: n_state = mtu_pkg::ST_IDLE;
        endcase
    end

    // beat stream into the head of the chain
    always_comb begin
        w_ctl[0] = '0;
        for (int r = 0; r < 4; r++) begin
            w_bv[0][r] = '0;
        end
        if (w_feed) begin
            case (r_cmd)
                mtu_pkg::CMD_LOAD_CUR: begin
                    w_ctl[0].op   = mtu_pkg::OP_LOAD;
                    w_ctl[0].row  = r_idx[3:2];
                    w_ctl[0].k    = r_idx[1:0];
                    w_ctl[0].last = 1'b1;
                    for (int r = 0; r < 4; r++) w_bv[0][r] = BW'(r_val);
                end
                mtu_pkg::CMD_IDENT: begin
                    w_ctl[0].op   = mtu_pkg::OP_IDENT;
                    w_ctl[0].last = 1'b1;
                end
                mtu_pkg::CMD_MUL: begin
                    if (r_cnt[4]) begin
                        w_ctl[0].op   = mtu_pkg::OP_COMMIT;
                        w_ctl[0].last = 1'b1;
                    end else begin
                        w_ctl[0].op = mtu_pkg::OP_MAC;
                        w_ctl[0].j  = r_cnt[3:2];
                        w_ctl[0].k  = r_cnt[1:0];
                        for (int r = 0; r < 4; r++) begin
                            w_bv[0][r] = BW'(r_opm[{r_cnt[1:0], r_cnt[3:2]}]);
                        end
                    end
                end
                mtu_pkg::CMD_ADD: begin
                    if (r_cnt[2]) begin
                        w_ctl[0].op   = mtu_pkg::OP_COMMIT;
                        w_ctl[0].last = 1'b1;
                    end else begin
                        w_ctl[0].op = mtu_pkg::OP_ADD;
                        w_ctl[0].k  = r_cnt[1:0];
                        for (int r = 0; r < 4; r++) begin
                            w_bv[0][r] = BW'(r_opm[{2'(r), r_cnt[1:0]}]);
                        end
                    end
                end
                mtu_pkg::CMD_XFORM: begin
                    w_ctl[0].op   = mtu_pkg::OP_MAC;
                    w_ctl[0].k    = r_cnt[1:0];
                    w_ctl[0].last = (r_cnt[1:0] == 2'd3);
                    for (int r = 0; r < 4; r++) w_bv[0][r] = BW'(r_vec[r_cnt[1:0]]);
                end
                default: w_ctl[0] = '0;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_cell
            mtu_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .FRAC_BITS  (FRAC_BITS),
                .BUS_WIDTH  (BW),
                .IDX        (2'(g))
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_bv    (w_bv[g]),
                .o_ctl   (w_ctl[g+1]),
                .o_bv    (w_bv[g+1]),
                .o_stat  (w_stat[g]),
                .o_res   (w_res[g])
            );
        end
    endgenerate

    // clamp transform results to the output range
    always_comb begin
        logic signed [63:0] ext;
        logic signed [63:0] hi;
        for (int i = 0; i < 4; i++) begin
            ext = 64'(w_res[i]);
            hi  = ext >>> 31;
            if (hi == 64'sd0 || hi == -64'sd1) begin
                w_res32[i]   = ext[31:0];
                w_res_ovf[i] = 1'b0;
            end else begin
                w_res32[i]   = ext[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                w_res_ovf[i] = 1'b1;
            end
        end
    end

    always_comb begin
        w_any_ovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_any_ovf = w_any_ovf || w_stat[i].ovf ||
                        (w_stat[i].res_valid && w_res_ovf[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtu_pkg::ST_IDLE;
            r_cnt   <= '0;
            for (int i = 0; i < 16; i++) r_opm[i] <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc_in) begin
                r_cnt <= '0;
                if (mtu_pkg::t_cmd'(i_cmd) == mtu_pkg::CMD_LOAD_OP) begin
                    r_opm[i_elem_index] <= w_lv_sat;
                end
            end else if (w_feed) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_cmd    <= mtu_pkg::t_cmd'(i_cmd);
            r_idx    <= i_elem_index;
            r_val    <= w_lv_sat;
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_vec[3] <= i_vec_w;
            r_ovf    <= 1'b0;
            for (int i = 0; i < 4; i++) r_out[i] <= '0;
        end else begin
            if (w_any_ovf) r_ovf <= 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (w_stat[i].res_valid && r_cmd == mtu_pkg::CMD_XFORM) begin
                    r_out[i] <= w_res32[i];
                end
            end
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> o_stall)
        else $error("accepted beat did not hold off the input");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat[3].done |-> (r_state == mtu_pkg::ST_WAIT))
        else $error("chain finished outside of wait");

    a_zero_unless_xform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != mtu_pkg::CMD_XFORM) |->
        (o_out_x == 0 && o_out_y == 0 && o_out_z == 0 && o_out_w == 0))
        else $error("nonzero vector on a non-transform result");

endmodule

`default_nettype wire

>>> verif/matrix4x4_transform_unit_core_tb.sv
`timescale 1ns / 1ps

module matrix4x4_transform_unit_core_tb;

    localparam int  ONE_Q    = 1 << mtu_pkg::FRAC_BITS;
    localparam int  MAX_CYC  = 400000;
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef struct {
        logic [2:0]         cmd;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] vx, vy, vz, vw;
    } t_beat;

    typedef struct {
        logic signed [31:0] x, y, z, w;
        logic               ovf;
    } t_res;

    typedef struct {
        t_beat b;
        bit    fixed;
        t_res  r;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic [2:0]         i_cmd = '0;
    logic [3:0]         i_elem_index = '0;
    logic signed [31:0] i_elem_value = '0;
    logic signed [31:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0, i_vec_w = '0;
    wire                o_stall, o_valid, o_overflow;
    wire signed [31:0]  o_out_x, o_out_y, o_out_z, o_out_w;

    matrix4x4_transform_unit_core uut (.*);

    always #1 i_clk = ~i_clk;

    logic signed [31:0] cur_m [16];
    logic signed [31:0] opd_m [16];
    t_res               pending_res [$];
    int                 errors = 0;
    int                 n_sent = 0, n_got = 0, n_xform = 0, n_ovf = 0;
    int                 cyc = 0;
    bit                 calm = 0;

    function automatic logic signed [31:0] clamp_dot(logic signed [127:0] acc,
                                                     ref bit ovf);
        logic signed [127:0] s;
        s = acc >>> mtu_pkg::FRAC_BITS;
        if (s > 128'sd2147483647) begin
            ovf = 1;
            return SMAX;
        end
        if (s < -128'sd2147483648) begin
            ovf = 1;
            return SMIN;
        end
        return s[31:0];
    endfunction

    function automatic t_res matrix_apply(t_beat b);
        t_res r;
        bit ovf;
        logic signed [127:0] acc;
        logic signed [31:0] tmp [16];
        logic signed [31:0] v [4];
        logic signed [32:0] sm;
        ovf = 0;
        r = '{0, 0, 0, 0, 0};
        v = '{b.vx, b.vy, b.vz, b.vw};
        case (b.cmd)
            mtu_pkg::CMD_LOAD_CUR: cur_m[b.idx] = b.val;
            mtu_pkg::CMD_LOAD_OP:  opd_m[b.idx] = b.val;
            mtu_pkg::CMD_IDENT: for (int i = 0; i < 16; i++) cur_m[i] = (i % 5 == 0) ? ONE_Q : 0;
            mtu_pkg::CMD_MUL: begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += 128'(cur_m[i*4+k]) * 128'(opd_m[k*4+j]);
                        tmp[i*4+j] = clamp_dot(acc, ovf);
                    end
                cur_m = tmp;
            end
            mtu_pkg::CMD_ADD: for (int i = 0; i < 16; i++) begin
                sm = 33'(cur_m[i]) + 33'(opd_m[i]);
                if (sm > 33'sd2147483647) begin
                    ovf = 1;
                    cur_m[i] = SMAX;
                end else if (sm < -33'sd2147483648) begin
                    ovf = 1;
                    cur_m[i] = SMIN;
                end else cur_m[i] = sm[31:0];
            end
            mtu_pkg::CMD_XFORM: for (int i = 0; i < 4; i++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += 128'(cur_m[i*4+k]) * 128'(v[k]);
                tmp[i] = clamp_dot(acc, ovf);
            end
            default: ;
        endcase
        if (b.cmd == mtu_pkg::CMD_XFORM) begin
            r.x = tmp[0];
            r.y = tmp[1];
            r.z = tmp[2];
            r.w = tmp[3];
        end
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? SMAX : SMIN;
            2: return $signed($urandom_range(0, 2*ONE_Q)) - ONE_Q;
            default: return $signed($urandom_range(0, 8*ONE_Q)) - 4*ONE_Q;
        endcase
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        int p;
        p = $urandom_range(0, 99);
        b.cmd = p < 35 ? mtu_pkg::CMD_LOAD_CUR : p < 60 ? mtu_pkg::CMD_LOAD_OP :
                p < 64 ? mtu_pkg::CMD_IDENT : p < 75 ? mtu_pkg::CMD_MUL :
                p < 80 ? mtu_pkg::CMD_ADD : p < 96 ? mtu_pkg::CMD_XFORM :
                3'($urandom_range(6, 7));
        b.idx = 4'($urandom);
        b.val = rand_elem();
        b.vx = rand_elem();
        b.vy = rand_elem();
        b.vz = rand_elem();
        b.vw = rand_elem();
        return b;
    endfunction

    task automatic send_beat(t_beat b);
        i_valid      <= 1'b1;
        i_cmd        <= b.cmd;
        i_elem_index <= b.idx;
        i_elem_value <= b.val;
        i_vec_x      <= b.vx;
        i_vec_y      <= b.vy;
        i_vec_z      <= b.vz;
        i_vec_w      <= b.vw;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
        if (b.cmd == mtu_pkg::CMD_XFORM) n_xform++;
    endtask

    task automatic idle_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("matrix4x4_transform_unit_core: mismatch");
            $finish;
        end
    end

    // result side: random stall bursts, compare each beat against the oldest prediction
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_got <= n_got + 1;
            if (pending_res.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x exp %h got %h", e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y exp %h got %h", e.y, o_out_y);
                    errors++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z exp %h got %h", e.z, o_out_z);
                    errors++;
                end
                if (o_out_w !== e.w) begin
                    $error("out_w exp %h got %h", e.w, o_out_w);
                    errors++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow exp %b got %b", e.ovf, o_overflow);
                    errors++;
                end
                if (e.ovf) n_ovf <= n_ovf + 1;
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else i_stall <= 1'b0;
    end

    t_row dir [$];

    function automatic t_beat mk(logic [2:0] c, logic [3:0] ix, logic signed [31:0] v,
                                 logic signed [31:0] x = 0, logic signed [31:0] y = 0,
                                 logic signed [31:0] z = 0, logic signed [31:0] w = 0);
        t_beat b;
        b = '{c, ix, v, x, y, z, w};
        return b;
    endfunction

    initial begin
        t_res zr, r;
        zr = '{0, 0, 0, 0, 0};
        for (int i = 0; i < 16; i++) begin
            cur_m[i] = (i % 5 == 0) ? ONE_Q : 0;
            opd_m[i] = 0;
        end
        // after reset: identity passes the vector through
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 0, 0, SMAX, SMIN, 32'sd5, -32'sd7), 1,
                        '{SMAX, SMIN, 32'sd5, -32'sd7, 0}});
        dir.push_back('{mk(mtu_pkg::CMD_MUL, 0, 0), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 0, 0, SMAX, SMAX, SMAX, SMAX), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_IDENT, 4'hf, SMIN), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_CUR, 4'd0, SMAX), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_CUR, 4'd1, SMAX), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_OP, 4'd0, SMAX), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_OP, 4'd15, SMIN), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_ADD, 0, 0), 0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 0, 0, SMAX, SMAX, SMIN, SMIN), 0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 4'hf, 0, SMIN, SMIN, SMIN, SMIN), 0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_MUL, 0, 0), 0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_RSVD6, 4'h5, SMAX, SMAX, SMAX, SMAX, SMAX), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_RSVD7, 4'ha, SMIN, SMIN, SMIN, SMIN, SMIN), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_IDENT, 0, 0), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_OP, 4'd5, -32'sd1), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_ADD, 0, 0), 0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 0, 0, -32'sd1, -32'sd1, -32'sd1, -32'sd1),
                        0, zr});
        dir.push_back('{mk(mtu_pkg::CMD_LOAD_CUR, 4'd10, SMIN), 1, zr});
        dir.push_back('{mk(mtu_pkg::CMD_XFORM, 0, 0, 0, 0, SMIN, 0), 0, zr});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir[i]) begin
            r = matrix_apply(dir[i].b);
            pending_res.push_back(dir[i].fixed ? dir[i].r : r);
            send_beat(dir[i].b);
            idle_gap();
        end
        for (int i = 0; i < 500; i++) begin
            t_beat b;
            if (i >= 440) calm = 1;
            b = rand_beat();
            pending_res.push_back(matrix_apply(b));
            send_beat(b);
            idle_gap();
        end
        i_valid <= 1'b0;
        calm = 1;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("beats sent %0d, results %0d, transforms %0d, saturating results %0d",
                 n_sent, n_got, n_xform, n_ovf);
        if (errors == 0 && pending_res.size() == 0)
            $display("matrix4x4_transform_unit_core: match");
        else
            $display("matrix4x4_transform_unit_core: mismatch");
        $finish;
    end
endmodule

>>> sim.f
design/mtu_pkg.sv
design/mtu_cell.sv
design/matrix4x4_transform_unit_core.sv
verif/matrix4x4_transform_unit_core_tb.sv
